/* design/pft_pkg.sv */
// Package for the page frame tracker: sizes, flag masks, controller states
// and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package pft_pkg;

    localparam int DIR_ENTRIES = 64;
    localparam int DIR_W       = (DIR_ENTRIES > 1) ? $clog2(DIR_ENTRIES) : 1;
    localparam int TBL_ENTRIES = 1024;
    localparam int ENT_W       = 10;
    localparam int TBL_SHIFT   = 22;
    localparam int PAGE_SHIFT  = 12;
    localparam int CNT_W       = 11;

    localparam logic [9:0]       IDX_MASK    = 10'h3FF;
    localparam logic [7:0]       KEEP_MASK   = 8'h03;
    localparam logic [7:0]       TAKE_MASK   = 8'hFC;
    localparam logic [CNT_W-1:0] COUNT_MAX   = 11'd2047;
    localparam logic [32:0]      PAGE_BYTES  = 33'd4096;

    localparam int FL_PRESENT  = 0;
    localparam int FL_RESERVED = 1;
    localparam int FL_MAPPED   = 2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PAGE,
        ST_CLEAR,
        ST_PUPD,
        ST_TRD,
        ST_TEVAL,
        ST_ERD,
        ST_ECHK,
        ST_DONE
    } pft_state_t;

    typedef struct packed {
        logic load;
        logic page_adv;
        logic set_beyond;
        logic clr_step;
        logic tbl_create;
        logic page_upd;
        logic t_adv;
        logic e_adv;
        logic set_found;
        logic finish;
    } pft_cmd_t;

    typedef struct packed {
        logic op;
        logic in_range;
        logic beyond;
        logic tbl_valid;
        logic owner_zero;
        logic clr_last;
        logic srch_eligible;
        logic t_last;
        logic entry_free;
        logic e_last;
    } pft_sts_t;

endpackage

`default_nettype wire

/* design/pft_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pft_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                                       clk,
    input  wire logic                                       we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                           wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end

endmodule

`default_nettype wire

/* design/pft_ctrl.sv */
// Controller state machine for the page frame tracker.
// Depends on pft_pkg for states and the command/status structs.
`default_nettype none

module pft_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              start,
    input  wire pft_pkg::pft_sts_t sts,
    output pft_pkg::pft_cmd_t      cmd,
    output logic                   busy
);

    pft_pkg::pft_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= pft_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            pft_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = pft_pkg::ST_PAGE;
                end
            end
            pft_pkg::ST_PAGE:
            begin
                // search ops pass through here once and go to the table walk
                if (sts.op)
                begin
                    state_next = pft_pkg::ST_TRD;
                end
                else if (!sts.in_range)
                begin
                    state_next = pft_pkg::ST_DONE;
                end
                else if (sts.beyond)
                begin
                    cmd.set_beyond = 1'b1;
                    cmd.page_adv   = 1'b1;
                end
                else if (!sts.tbl_valid)
                begin
                    if (sts.owner_zero)
                    begin
                        state_next = pft_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        cmd.page_adv = 1'b1;
                    end
                end
                else
                begin
                    state_next = pft_pkg::ST_PUPD;
                end
            end
            pft_pkg::ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last)
                begin
                    cmd.tbl_create = 1'b1;
                    state_next     = pft_pkg::ST_PAGE;
                end
            end
            pft_pkg::ST_PUPD:
            begin
                cmd.page_upd = 1'b1;
                cmd.page_adv = 1'b1;
                state_next   = pft_pkg::ST_PAGE;
            end
            pft_pkg::ST_TRD:
            begin
                state_next = pft_pkg::ST_TEVAL;
            end
            pft_pkg::ST_TEVAL:
            begin
                if (sts.srch_eligible)
                begin
                    state_next = pft_pkg::ST_ERD;
                end
                else if (sts.t_last)
                begin
                    state_next = pft_pkg::ST_DONE;
                end
                else
                begin
                    cmd.t_adv  = 1'b1;
                    state_next = pft_pkg::ST_TRD;
                end
            end
            pft_pkg::ST_ERD:
            begin
                state_next = pft_pkg::ST_ECHK;
            end
            pft_pkg::ST_ECHK:
            begin
                if (sts.entry_free)
                begin
                    cmd.set_found = 1'b1;
                    state_next    = pft_pkg::ST_DONE;
                end
                else if (!sts.e_last)
                begin
                    cmd.e_adv  = 1'b1;
                    state_next = pft_pkg::ST_ERD;
                end
                else if (sts.t_last)
                begin
                    state_next = pft_pkg::ST_DONE;
                end
                else
                begin
                    cmd.e_adv  = 1'b1;
                    cmd.t_adv  = 1'b1;
                    state_next = pft_pkg::ST_TRD;
                end
            end
            pft_pkg::ST_DONE:
            begin
                cmd.finish = 1'b1;
                state_next = pft_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = pft_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != pft_pkg::ST_IDLE);

`ifndef SYNTHESIS
    a_clear_exit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pft_pkg::ST_CLEAR |=>
            state_reg == pft_pkg::ST_CLEAR || state_reg == pft_pkg::ST_PAGE)
        else $error("clear sweep left to an unexpected state");
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == pft_pkg::ST_DONE |=> state_reg == pft_pkg::ST_IDLE)
        else $error("result cycle not followed by idle");
    a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |-> !busy)
        else $error("load issued while busy");
`endif

endmodule

`default_nettype wire

/* design/pft_dp.sv */
// Datapath for the page frame tracker: walk registers, table valid bits,
// free counter RAM, page flag RAM and result registers.
// Depends on pft_pkg and pft_ram.
`default_nettype none

module pft_dp (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire pft_pkg::pft_cmd_t cmd,
    output pft_pkg::pft_sts_t      sts,
    input  wire logic              op,
    input  wire logic [31:0]       range_base,
    input  wire logic [31:0]       range_bytes,
    input  wire logic [15:0]       owner_id,
    input  wire logic [7:0]        page_flags_in,
    output logic                   done,
    output logic                   found,
    output logic [31:0]            page_addr,
    output logic                   status
);

    localparam int DW = pft_pkg::DIR_W;
    localparam int EW = pft_pkg::ENT_W;
    localparam int CW = pft_pkg::CNT_W;

    logic                op_reg;
    logic [32:0]         addr_reg;
    logic [32:0]         end_reg;
    logic                owner_zero_reg;
    logic [7:0]          flags_reg;
    logic [pft_pkg::DIR_ENTRIES-1:0] valid_reg;
    logic [EW-1:0]       clr_reg;
    logic [DW-1:0]       srch_t_reg;
    logic [EW-1:0]       srch_e_reg;
    logic                found_reg;
    logic                status_reg;
    logic                done_reg;

    logic [DW-1:0]       tidx;
    logic [EW-1:0]       eidx;
    logic [7:0]          old_flags;
    logic [CW-1:0]       cnt_rdata;
    logic                page_write;
    logic [7:0]          new_flags;
    logic [CW-1:0]       new_cnt;
    logic                cnt_up;
    logic                cnt_down;

    logic                flag_we;
    logic [DW+EW-1:0]    flag_waddr;
    logic [DW+EW-1:0]    flag_raddr;
    logic [7:0]          flag_wdata;
    logic                cnt_we;
    logic [DW-1:0]       cnt_raddr;
    logic [CW-1:0]       cnt_wdata;

    assign tidx = addr_reg[pft_pkg::TBL_SHIFT +: DW];
    assign eidx = addr_reg[pft_pkg::PAGE_SHIFT +: EW];

    // per-page update rules
    always_comb
    begin
        page_write = 1'b0;
        new_flags  = old_flags;
        cnt_up     = 1'b0;
        cnt_down   = 1'b0;
        if (owner_zero_reg)
        begin
            page_write = 1'b1;
            new_flags  = flags_reg;
            cnt_up     = flags_reg[pft_pkg::FL_PRESENT] & ~flags_reg[pft_pkg::FL_RESERVED];
        end
        else if (old_flags[pft_pkg::FL_PRESENT])
        begin
            page_write = 1'b1;
            new_flags  = (old_flags & pft_pkg::KEEP_MASK) | (flags_reg & pft_pkg::TAKE_MASK);
            if (!old_flags[pft_pkg::FL_RESERVED])
            begin
                cnt_down = flags_reg[pft_pkg::FL_MAPPED] & ~old_flags[pft_pkg::FL_MAPPED];
                cnt_up   = ~flags_reg[pft_pkg::FL_MAPPED] & old_flags[pft_pkg::FL_MAPPED];
            end
        end
        new_cnt = cnt_rdata;
        if (cnt_up && cnt_rdata != pft_pkg::COUNT_MAX)
        begin
            new_cnt = cnt_rdata + CW'(1);
        end
        else if (cnt_down && cnt_rdata != '0)
        begin
            new_cnt = cnt_rdata - CW'(1);
        end
    end

    assign flag_we    = cmd.clr_step | (cmd.page_upd & page_write);
    assign flag_waddr = {tidx, (cmd.clr_step ? clr_reg : eidx)};
    assign flag_wdata = cmd.clr_step ? 8'h00 : new_flags;
    assign flag_raddr = op_reg ? {srch_t_reg, srch_e_reg} : {tidx, eidx};

    assign cnt_we    = cmd.tbl_create | (cmd.page_upd & page_write);
    assign cnt_wdata = cmd.tbl_create ? '0 : new_cnt;
    assign cnt_raddr = op_reg ? srch_t_reg : tidx;

    pft_ram #(
        .WIDTH (8),
        .DEPTH (pft_pkg::DIR_ENTRIES * pft_pkg::TBL_ENTRIES)
    ) u_flag_ram (
        .clk   (clk),
        .we    (flag_we),
        .waddr (flag_waddr),
        .wdata (flag_wdata),
        .raddr (flag_raddr),
        .rdata (old_flags)
    );

    pft_ram #(
        .WIDTH (CW),
        .DEPTH (pft_pkg::DIR_ENTRIES)
    ) u_cnt_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (tidx),
        .wdata (cnt_wdata),
        .raddr (cnt_raddr),
        .rdata (cnt_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            found_reg  <= 1'b0;
            status_reg <= 1'b0;
            done_reg   <= 1'b0;
            op_reg     <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.finish;
            if (cmd.load)
            begin
                op_reg     <= op;
                found_reg  <= 1'b0;
                status_reg <= 1'b0;
            end
            if (cmd.set_beyond)
            begin
                status_reg <= 1'b1;
            end
            if (cmd.set_found)
            begin
                found_reg <= 1'b1;
            end
            if (cmd.tbl_create)
            begin
                valid_reg[tidx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            addr_reg       <= {1'b0, range_base};
            end_reg        <= {1'b0, range_base} + {1'b0, range_bytes};
            owner_zero_reg <= (owner_id == 16'h0000);
            flags_reg      <= page_flags_in;
            clr_reg        <= '0;
            srch_t_reg     <= '0;
            srch_e_reg     <= '0;
        end
        else
        begin
            if (cmd.page_adv)
            begin
                addr_reg <= addr_reg + pft_pkg::PAGE_BYTES;
            end
            // wraps back to zero at the end of each sweep
            if (cmd.clr_step)
            begin
                clr_reg <= clr_reg + EW'(1);
            end
            if (cmd.t_adv)
            begin
                srch_t_reg <= srch_t_reg + DW'(1);
            end
            if (cmd.e_adv)
            begin
                srch_e_reg <= srch_e_reg + EW'(1);
            end
        end
    end

    always_comb
    begin
        sts               = '0;
        sts.op            = op_reg;
        sts.in_range      = (addr_reg < end_reg) & ~addr_reg[32];
        sts.beyond        = {1'b0, addr_reg[31:22]} >= 11'(pft_pkg::DIR_ENTRIES);
        sts.tbl_valid     = valid_reg[tidx];
        sts.owner_zero    = owner_zero_reg;
        sts.clr_last      = (clr_reg == pft_pkg::IDX_MASK);
        sts.srch_eligible = valid_reg[srch_t_reg] & (cnt_rdata != '0);
        sts.t_last        = (srch_t_reg == DW'(pft_pkg::DIR_ENTRIES - 1));
        sts.entry_free    = old_flags[pft_pkg::FL_PRESENT] & ~old_flags[pft_pkg::FL_RESERVED]
                            & ~old_flags[pft_pkg::FL_MAPPED];
        sts.e_last        = (srch_e_reg == pft_pkg::IDX_MASK);
    end

    assign done      = done_reg;
    assign found     = found_reg;
    assign status    = status_reg;
    assign page_addr = found_reg ? ((32'(srch_t_reg) << pft_pkg::TBL_SHIFT)
                                    | (32'(srch_e_reg) << pft_pkg::PAGE_SHIFT)) : 32'h0;

`ifndef SYNTHESIS
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg)
        else $error("result strobe longer than one cycle");
    a_found_excl: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !(found_reg && status_reg))
        else $error("found and beyond-directory status both set");
    a_no_clear_valid: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clr_step |-> !valid_reg[tidx])
        else $error("clearing a table that is already valid");
`endif

endmodule

`default_nettype wire

/* design/page_frame_tracker.sv */
// Top level of the page frame tracker: controller plus datapath.
// Depends on pft_pkg, pft_ctrl, pft_dp (and pft_ram through pft_dp).
//
//  channel  | handshake        | payload
//  ---------+------------------+-----------------------------------------------
//  command  | start / busy     | op, range_base, range_bytes, owner_id, page_flags_in
//  result   | done (1 cycle)   | found, page_addr, status
//
// A command transfers on a clock edge with start high and busy low.
// Range update: each page is skipped in ST_PAGE or updated through ST_PUPD; every table
// created gets a clearing sweep of its 1024 entries (one flag RAM write per cycle).
// Free search: ST_TRD, ST_TEVAL per table looked at; ST_ERD, ST_ECHK per entry scanned.
// Reset clears table valid bits; no clearing pass runs after reset.
// The result strobe is not stalled; the next command may transfer in its cycle.
`default_nettype none

module page_frame_tracker (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        op,
    input  wire logic [31:0] range_base,
    input  wire logic [31:0] range_bytes,
    input  wire logic [15:0] owner_id,
    input  wire logic [7:0]  page_flags_in,
    output logic             done,
    output logic             found,
    output logic [31:0]      page_addr,
    output logic             status
);

    pft_pkg::pft_cmd_t cmd;
    pft_pkg::pft_sts_t sts;

    pft_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    pft_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .op            (op),
        .range_base    (range_base),
        .range_bytes   (range_bytes),
        .owner_id      (owner_id),
        .page_flags_in (page_flags_in),
        .done          (done),
        .found         (found),
        .page_addr     (page_addr),
        .status        (status)
    );

endmodule

`default_nettype wire
